### rtl/fbp_pkg.sv
package fbp_pkg;

    localparam int DEF_MAX_BINS  = 64;
    localparam int DEF_SIZE_BITS = 16;

    // Widths of the request and result fields at the ports.
    localparam int SIZE_PORT_W = 16;
    localparam int IDX_PORT_W  = 6;
    localparam int USED_PORT_W = 7;

    localparam logic [SIZE_PORT_W-1:0] CAP_RESET = 16'hFFFF;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_TOO_BIG = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    // Per-cell outcome for the request that sits in the cell this cycle.
    typedef struct packed {
        logic hit;      // item placed into this open bin
        logic opened;   // this cell is the first free bin and takes the item
    } cell_flags_t;

endpackage

### rtl/first_fit_bin_packer_top.sv
// A clear or an oversized item gives its result in the cycle after the request; an
// item placed into bin b passes through the cell registers of bins 0 to b and then the
// result register, and an item that finds every bin open and too full walks every cell
// and comes back with status full. Busy stays high while the item walks the bin chain,
// one cell per cycle; clear and reject requests are taken back to back.
// Reset (rst_n, async, active low) empties all bins and sets capacity to 65535.
// Results come out as a one-cycle strobe; the receiver cannot stall them.
module first_fit_bin_packer_top #(
    parameter int MAX_BINS  = fbp_pkg::DEF_MAX_BINS,
    parameter int SIZE_BITS = fbp_pkg::DEF_SIZE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             start,
    output logic                             busy,
    input  logic                             command,
    input  logic [fbp_pkg::SIZE_PORT_W-1:0]  item_size,
    // result channel
    output logic                             result_valid,
    output logic [fbp_pkg::IDX_PORT_W-1:0]   bin_index,
    output logic [fbp_pkg::SIZE_PORT_W-1:0]  space_left,
    output logic                             opened_new,
    output logic [fbp_pkg::USED_PORT_W-1:0]  bins_used,
    output logic [1:0]                       status,
    // capacity register write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fbp_pkg::SIZE_PORT_W-1:0]  cfg_data
);
    import fbp_pkg::*;

    // Sizes live in the low SIZE_BITS bits, never wider than the port.
    localparam int SZ_W  = (SIZE_BITS < SIZE_PORT_W) ? SIZE_BITS : SIZE_PORT_W;
    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    logic [SIZE_PORT_W-1:0] cap_reg;
    logic [CNT_W-1:0]       open_count_reg;
    logic                   busy_reg;

    logic                   result_valid_reg;
    logic [IDX_W-1:0]       res_idx_reg;
    logic [SZ_W-1:0]        res_space_reg;
    logic                   res_opened_reg;
    logic [CNT_W-1:0]       res_used_reg;
    status_t                res_status_reg;

    logic [SZ_W-1:0]        req_size;
    logic [SZ_W-1:0]        cap;
    logic                   accept;
    logic                   too_big;
    logic                   launch;

    // Request chain between cells; the entry past the last cell flags "no bin free".
    logic                   tok_valid [MAX_BINS+1];
    logic [SZ_W-1:0]        tok_size  [MAX_BINS+1];
    cell_flags_t            flags     [MAX_BINS];
    logic [SZ_W-1:0]        cell_space[MAX_BINS];

    logic                   any_hit;
    logic                   any_open;
    logic [IDX_W-1:0]       hit_idx;
    logic [SZ_W-1:0]        hit_space;
    logic                   chain_full;
    logic                   done;

    assign req_size = item_size[SZ_W-1:0];
    assign cap      = cap_reg[SZ_W-1:0];
    assign accept   = start & ~busy_reg;
    assign too_big  = req_size > cap;
    // Send a fitting place request into the first cell.
    assign launch   = accept & (command == CMD_PLACE) & ~too_big;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;

    assign tok_valid[0] = launch;
    assign tok_size[0]  = req_size;

    for (genvar i = 0; i < MAX_BINS; i++)
    begin : g_cell
        fbp_cell #(
            .IDX   (i),
            .SZ_W  (SZ_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_valid_in  (tok_valid[i]),
            .tok_size_in   (tok_size[i]),
            .open_count    (open_count_reg),
            .capacity      (cap),
            .tok_valid_out (tok_valid[i+1]),
            .tok_size_out  (tok_size[i+1]),
            .flags         (flags[i]),
            .res_space     (cell_space[i])
        );
    end

    // At most one cell reports per cycle; merge their outcomes.
    always_comb
    begin
        any_hit   = 1'b0;
        any_open  = 1'b0;
        hit_idx   = '0;
        hit_space = '0;
        for (int i = 0; i < MAX_BINS; i++)
        begin
            any_hit   = any_hit  | flags[i].hit;
            any_open  = any_open | flags[i].opened;
            hit_space = hit_space | cell_space[i];
            if (flags[i].hit | flags[i].opened)
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign chain_full = tok_valid[MAX_BINS];
    assign done       = any_hit | any_open | chain_full;

    // Hold busy from launch until the request lands or drops off the chain end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            open_count_reg   <= '0;
            cap_reg          <= CAP_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end

            if (launch)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end

            if (accept && command == CMD_CLEAR)
            begin
                open_count_reg <= '0;
            end
            else if (any_open)
            begin
                open_count_reg <= open_count_reg + 1'b1;
            end

            result_valid_reg <= (accept & ~launch) | done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_CLEAR)
        begin
            res_idx_reg    <= '0;
            res_space_reg  <= '0;
            res_opened_reg <= 1'b0;
            res_used_reg   <= '0;
            res_status_reg <= ST_CLEARED;
        end
        else if (accept && too_big)
        begin
            res_idx_reg    <= '0;
            res_space_reg  <= '0;
            res_opened_reg <= 1'b0;
            res_used_reg   <= open_count_reg;
            res_status_reg <= ST_TOO_BIG;
        end
        else if (chain_full)
        begin
            res_idx_reg    <= '0;
            res_space_reg  <= '0;
            res_opened_reg <= 1'b0;
            res_used_reg   <= open_count_reg;
            res_status_reg <= ST_FULL;
        end
        else if (any_hit || any_open)
        begin
            res_idx_reg    <= hit_idx;
            res_space_reg  <= hit_space;
            res_opened_reg <= any_open;
            res_used_reg   <= any_open ? open_count_reg + 1'b1 : open_count_reg;
            res_status_reg <= ST_PLACED;
        end
    end

    // Fit internal widths to the fixed port widths.
    logic [IDX_W+IDX_PORT_W-1:0]  idx_ext;
    logic [SZ_W+SIZE_PORT_W-1:0]  space_ext;
    logic [CNT_W+USED_PORT_W-1:0] used_ext;

    assign idx_ext   = {{IDX_PORT_W{1'b0}}, res_idx_reg};
    assign space_ext = {{SIZE_PORT_W{1'b0}}, res_space_reg};
    assign used_ext  = {{USED_PORT_W{1'b0}}, res_used_reg};

    assign result_valid = result_valid_reg;
    assign bin_index    = idx_ext[IDX_PORT_W-1:0];
    assign space_left   = space_ext[SIZE_PORT_W-1:0];
    assign opened_new   = res_opened_reg;
    assign bins_used    = used_ext[USED_PORT_W-1:0];
    assign status       = res_status_reg;

endmodule

### rtl/fbp_cell.sv
module fbp_cell #(
    parameter int IDX   = 0,
    parameter int SZ_W  = 16,
    parameter int CNT_W = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tok_valid_in,
    input  logic [SZ_W-1:0]      tok_size_in,
    input  logic [CNT_W-1:0]     open_count,
    input  logic [SZ_W-1:0]      capacity,
    output logic                 tok_valid_out,
    output logic [SZ_W-1:0]      tok_size_out,
    output fbp_pkg::cell_flags_t flags,
    output logic [SZ_W-1:0]      res_space
);
    import fbp_pkg::*;

    logic            tok_valid_reg;
    logic [SZ_W-1:0] tok_size_reg;
    logic [SZ_W-1:0] space_reg;
    logic [SZ_W-1:0] space_next;
    logic            is_open;
    logic            is_first_free;
    logic            fit;
    logic [SZ_W-1:0] minuend;
    logic [SZ_W-1:0] diff;

    assign is_open       = CNT_W'(IDX) < open_count;
    assign is_first_free = CNT_W'(IDX) == open_count;
    assign fit           = space_reg >= tok_size_reg;

    assign flags.hit    = tok_valid_reg & is_open & fit;
    assign flags.opened = tok_valid_reg & is_first_free;

    // One subtractor serves both the fill of an open bin and a fresh bin.
    assign minuend = is_open ? space_reg : capacity;
    assign diff    = minuend - tok_size_reg;

    assign res_space = (flags.hit | flags.opened) ? diff : '0;

    // Hand the request on when this bin is open but too full.
    assign tok_valid_out = tok_valid_reg & is_open & ~fit;
    assign tok_size_out  = tok_size_reg;

    always_comb
    begin
        space_next = space_reg;
        if (flags.hit | flags.opened)
        begin
            space_next = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_size_reg <= tok_size_in;
        space_reg    <= space_next;
    end

endmodule

### sim/first_fit_bin_packer_top_tb.sv
`timescale 1ns / 1ps

module first_fit_bin_packer_top_tb;

    import fbp_pkg::*;

    localparam int NUM_BINS       = DEF_MAX_BINS;
    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = NUM_BINS + 8;
    localparam int MAX_REPORTS    = 10;

    // One expected packing outcome, at the widths of the result ports.
    typedef struct {
        logic [IDX_PORT_W-1:0]  bin_idx;
        logic [SIZE_PORT_W-1:0] room;
        logic                   fresh;
        logic [USED_PORT_W-1:0] used;
        status_t                st;
    } packing_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   command;
    logic [SIZE_PORT_W-1:0] item_size;
    logic                   result_valid;
    logic [IDX_PORT_W-1:0]  bin_index;
    logic [SIZE_PORT_W-1:0] space_left;
    logic                   opened_new;
    logic [USED_PORT_W-1:0] bins_used;
    logic [1:0]             status;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SIZE_PORT_W-1:0] cfg_data;

    // Shadow of the packer: remaining room per bin, open bin count, capacity.
    logic [SIZE_PORT_W-1:0] bin_room [NUM_BINS];
    int                     bins_open;
    logic [SIZE_PORT_W-1:0] capacity;

    packing_result_t pending_placements[$];
    int              mismatch_count;
    int              error_count;
    int              quiet_cycles;

    first_fit_bin_packer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .item_size    (item_size),
        .result_valid (result_valid),
        .bin_index    (bin_index),
        .space_left   (space_left),
        .opened_new   (opened_new),
        .bins_used    (bins_used),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Work out the outcome of one accepted request with first-fit placement,
    // update the shadow state and queue the outcome for the checker.
    task automatic first_fit_place(input logic cmd, input logic [SIZE_PORT_W-1:0] size);
        packing_result_t r;
        int              b;
        bit              placed;
        r.bin_idx = '0;
        r.room    = '0;
        r.fresh   = 1'b0;
        r.used    = bins_open[USED_PORT_W-1:0];
        placed    = 1'b0;
        if (cmd == CMD_CLEAR)
        begin
            // Clear: drop every bin; the room array is dead until reopened.
            bins_open = 0;
            r.used    = '0;
            r.st      = ST_CLEARED;
        end
        else if (size > capacity)
        begin
            r.st = ST_TOO_BIG;
        end
        else
        begin
            // Scan open bins lowest first; take the first with enough room.
            for (b = 0; b < bins_open && !placed; b++)
            begin
                if (bin_room[b] >= size)
                begin
                    bin_room[b] = bin_room[b] - size;
                    r.bin_idx   = b[IDX_PORT_W-1:0];
                    r.room      = bin_room[b];
                    r.st        = ST_PLACED;
                    placed      = 1'b1;
                end
            end
            if (!placed)
            begin
                if (bins_open >= NUM_BINS)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    // Open the next bin at the current capacity.
                    bin_room[bins_open] = capacity - size;
                    r.bin_idx           = bins_open[IDX_PORT_W-1:0];
                    r.room              = bin_room[bins_open];
                    r.fresh             = 1'b1;
                    bins_open           = bins_open + 1;
                    r.used              = bins_open[USED_PORT_W-1:0];
                    r.st                = ST_PLACED;
                end
            end
        end
        pending_placements.push_back(r);
    endtask

    // Present one request and hold it until the packer takes it. Leave start
    // high on return so a following request can go out back to back.
    task automatic send_request(input logic cmd, input logic [SIZE_PORT_W-1:0] size);
        start     <= 1'b1;
        command   <= cmd;
        item_size <= size;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        first_fit_place(cmd, size);
    endtask

    // Idle the sender for a random number of cycles, pct chances in 100 each.
    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop start and wait until every queued outcome has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
    endtask

    // Write the bin capacity register; only done with the packer idle.
    task automatic write_capacity(input logic [SIZE_PORT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity = value;
    endtask

    // Edge cases of size and capacity, including zero-size items, an item of
    // exactly the capacity, capacity zero and capacity one.
    task automatic test_size_extremes();
        // Reset capacity is in force here.
        send_request(CMD_PLACE, 16'd0);
        send_request(CMD_PLACE, 16'hFFFF);
        send_request(CMD_PLACE, 16'd1);
        send_request(CMD_PLACE, 16'd0);
        send_request(CMD_CLEAR, 16'hFFFF);
        write_capacity(16'd0);
        send_request(CMD_PLACE, 16'd0);
        send_request(CMD_PLACE, 16'd1);
        send_request(CMD_PLACE, 16'hFFFF);
        send_request(CMD_CLEAR, 16'd0);
        write_capacity(16'd1);
        send_request(CMD_PLACE, 16'd2);
        send_request(CMD_PLACE, 16'd1);
        send_request(CMD_PLACE, 16'd0);
        send_request(CMD_PLACE, 16'd1);
        send_request(CMD_CLEAR, 16'd0);
        write_capacity(16'hFFFF);
        send_request(CMD_PLACE, 16'hFFFF);
        send_request(CMD_PLACE, 16'h8000);
        send_request(CMD_PLACE, 16'h7FFF);
        send_request(CMD_PLACE, 16'h5555);
        send_request(CMD_PLACE, 16'hAAAA);
        send_request(CMD_CLEAR, 16'd0);
    endtask

    // Open bins under one capacity, shrink it, and check that old bins keep
    // their room while new bins get the new capacity.
    task automatic test_capacity_change();
        write_capacity(16'd100);
        send_request(CMD_PLACE, 16'd60);
        send_request(CMD_PLACE, 16'd70);
        write_capacity(16'd50);
        send_request(CMD_PLACE, 16'd40);
        send_request(CMD_PLACE, 16'd45);
        send_request(CMD_PLACE, 16'd60);
        send_request(CMD_PLACE, 16'd30);
        send_request(CMD_CLEAR, 16'd0);
    endtask

    // Open every bin, then ask for one more: the request walks the whole
    // chain and comes back full; a zero-size item still fits bin zero.
    task automatic test_all_bins_open();
        int i;
        write_capacity(16'd1);
        for (i = 0; i < NUM_BINS; i++)
            send_request(CMD_PLACE, 16'd1);
        send_request(CMD_PLACE, 16'd1);
        send_request(CMD_PLACE, 16'd0);
        send_request(CMD_PLACE, 16'd2);
        send_request(CMD_CLEAR, 16'd0);
    endtask

    // Random requests under one capacity and one idling rate. Sizes lean
    // toward fractions of the capacity so bins fill and the chain goes deep.
    // The next capacity write or the final wait drains what is left.
    task automatic test_random_phase(input logic [SIZE_PORT_W-1:0] cap, input int pct,
                                     input int count);
        int i;
        int pick;
        int cap_i;
        int size_i;
        write_capacity(cap);
        cap_i = cap;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                send_request(CMD_CLEAR, 16'($urandom));
            end
            else
            begin
                if (pick < 9 && cap_i < 16'hFFFF)
                    size_i = $urandom_range(16'hFFFF, cap_i + 1);
                else if (pick < 14)
                    size_i = 0;
                else if (pick < 20)
                    size_i = cap_i;
                else if (pick < 32)
                    size_i = $urandom_range(cap_i, 0);
                else
                    size_i = $urandom_range((cap_i / 3 > 1) ? cap_i / 3 : 1, 1);
                send_request(CMD_PLACE, size_i[SIZE_PORT_W-1:0]);
            end
            sender_gap(pct);
        end
    endtask

    // Compare each strobed result with the oldest queued outcome.
    always @(posedge clk)
    begin
        packing_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_placements.size() == 0)
            begin
                error_count++;
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: bin %0d room %0d new %0b used %0d status %0d",
                             bin_index, space_left, opened_new, bins_used, status);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_placements.pop_front();
                if (bin_index !== exp_r.bin_idx || space_left !== exp_r.room ||
                    opened_new !== exp_r.fresh || bins_used !== exp_r.used ||
                    status !== exp_r.st)
                begin
                    error_count++;
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: exp %0d/%0d/%0b/%0d/%0d got %0d/%0d/%0b/%0d/%0d",
                                 exp_r.bin_idx, exp_r.room, exp_r.fresh, exp_r.used,
                                 exp_r.st, bin_index, space_left, opened_new,
                                 bins_used, status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no request, result or register write
    // is accepted, and give up once that stretch grows too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("first_fit_bin_packer_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_PLACE;
        item_size      = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        bins_open      = 0;
        capacity       = CAP_RESET;
        mismatch_count = 0;
        error_count    = 0;
        quiet_cycles   = 0;
        for (int i = 0; i < NUM_BINS; i++)
            bin_room[i] = '0;

        // Hold reset, then release it on an edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_extremes();
        test_capacity_change();
        test_all_bins_open();
        // Phases: no idling at full capacity, heavy idling with a small
        // capacity, capacity one for constant full bins, light idling with
        // a random capacity.
        test_random_phase(16'hFFFF, 0, 165);
        test_random_phase(16'($urandom_range(300, 8)), 70, 165);
        test_random_phase(16'd1, 0, 150);
        test_random_phase(16'($urandom_range(16'hFFFF, 1)), 22, 165);

        // Let the longest chain walk finish before judging.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_placements.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("first_fit_bin_packer_top regression: pass");
        else
            $display("first_fit_bin_packer_top regression: fail");
        $finish;
    end

endmodule
